[rtl/lesf_pkg.sv]
package lesf_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned ColW  = 10;
  localparam int unsigned RowW  = 16;
  localparam int unsigned SideW = 11;

  // Largest side a square can have, and the widest row the column counter covers.
  localparam int unsigned SideCap = 1024;

  typedef logic [CharW-1:0] char_t;
  typedef logic [ColW-1:0]  col_t;
  typedef logic [RowW-1:0]  row_t;
  typedef logic [SideW-1:0] side_t;

  // Register index, taken from the word address bit of the configuration port.
  typedef enum logic {
    RegObstacle = 1'b0,
    RegWidth    = 1'b1
  } reg_idx_e;

  // Sides of the three neighbors of the current cell, already masked at map edges.
  typedef struct packed {
    side_t up;
    side_t diag;
    side_t left;
  } nbr_t;

  // Position of the current cell.
  typedef struct packed {
    row_t row;
    col_t col;
  } pos_t;

  // Candidate for the best square, found at the current cell.
  typedef struct packed {
    logic  update;
    row_t  row;
    col_t  col;
  } cand_t;

endpackage

[rtl/largest_empty_square_finder_unit.sv]
// Largest empty square finder.
// Map cells stream in on the s_axis channel in raster order, one byte per
// request in s_axis_tdata; s_axis_tlast marks the final cell of a map. Rows
// hold row_width cells; a cell equal to obstacle_char is blocked.
// On the final cell one result leaves on the m_axis channel: the row, column
// and side of the largest obstacle-free square (first one in row-major order
// of its top-left corner wins ties; all zero if every cell is blocked).
// The block takes one cell per cycle while s_axis is not stalled, set by the single
// read port and single write port of the line buffer that holds the previous row's
// sides. After the final cell is accepted, the result passes through the input
// register and then the output register before it is valid.
// A finished result waits in the output register while following cells are
// still taken; only a second final cell stalls s_axis until the result is
// taken. Reset clears the counters, the best square and both channels, and
// loads obstacle_char = 111 and row_width = 16. The line buffer needs no
// clearing. Configuration is written over the APB port, obstacle_char at address 0 and
// row_width at address 4; the user must write it only while the block is idle, which it does not enforce.
module largest_empty_square_finder_unit #(
  parameter int unsigned MaxCols = 1024,
  parameter int unsigned MaxRows = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // s_axis_tdata: [7:0] cell_char
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  // m_axis_tdata: [15:0] best_row, [25:16] best_col, [36:26] best_size, [39:37] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned ColLimit = (MaxCols < 1024) ? MaxCols : 1024;
  localparam int unsigned RowSat   = ((MaxRows - 1) < 65535) ? (MaxRows - 1) : 65535;
  localparam int unsigned AddrW    = (ColLimit > 1) ? $clog2(ColLimit) : 1;
  localparam int unsigned SideW    = lesf_pkg::SideW;
  localparam int unsigned ColW     = lesf_pkg::ColW;
  localparam int unsigned RowW     = lesf_pkg::RowW;

  // Configuration registers.
  lesf_pkg::char_t obstacle_q;
  lesf_pkg::side_t width_q;
  logic            cfg_wr;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obstacle_q <= lesf_pkg::char_t'(111);
      width_q    <= lesf_pkg::side_t'(16);
    end else if (cfg_wr) begin
      unique case (lesf_pkg::reg_idx_e'(paddr[2]))
        lesf_pkg::RegObstacle: obstacle_q <= pwdata[lesf_pkg::CharW-1:0];
        lesf_pkg::RegWidth:    width_q    <= pwdata[SideW-1:0];
        default:               obstacle_q <= obstacle_q;
      endcase
    end
  end

  always_comb begin
    unique case (lesf_pkg::reg_idx_e'(paddr[2]))
      lesf_pkg::RegObstacle: prdata = {{(32-lesf_pkg::CharW){1'b0}}, obstacle_q};
      lesf_pkg::RegWidth:    prdata = {{(32-SideW){1'b0}}, width_q};
      default:               prdata = '0;
    endcase
  end

  // Effective row width.
  lesf_pkg::side_t w_eff;

  always_comb begin
    if (width_q == '0) begin
      w_eff = SideW'(1);
    end else if (width_q > SideW'(ColLimit)) begin
      w_eff = SideW'(ColLimit);
    end else begin
      w_eff = width_q;
    end
  end

  // Position counters advance when a cell is accepted; they do not depend on cell data.
  lesf_pkg::col_t col_cnt_q, col_cnt_d;
  lesf_pkg::row_t row_cnt_q, row_cnt_d;
  lesf_pkg::col_t col_new;
  lesf_pkg::row_t row_new;
  logic [ColW:0]  col_plus;
  logic           in_acc;

  function automatic lesf_pkg::row_t row_inc(input lesf_pkg::row_t r);
    lesf_pkg::row_t res;
    res = r;
    if (r < RowW'(RowSat)) begin
      res = r + RowW'(1);
    end
    return res;
  endfunction

  always_comb begin
    if ({1'b0, col_cnt_q} >= w_eff) begin
      col_new = '0;
      row_new = row_inc(row_cnt_q);
    end else begin
      col_new = col_cnt_q;
      row_new = row_cnt_q;
    end
    col_plus = {1'b0, col_new} + (ColW+1)'(1);
    if (s_axis_tlast) begin
      col_cnt_d = '0;
      row_cnt_d = '0;
    end else if (col_plus >= w_eff) begin
      col_cnt_d = '0;
      row_cnt_d = row_inc(row_new);
    end else begin
      col_cnt_d = col_plus[ColW-1:0];
      row_cnt_d = row_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (in_acc) begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // Input stage.
  logic            s1_valid_q;
  lesf_pkg::char_t s1_char_q;
  logic            s1_last_q;
  lesf_pkg::pos_t  s1_pos_q;
  logic            fwd_q;
  lesf_pkg::side_t fwd_side_q;
  lesf_pkg::side_t rdata_q;
  logic            s1_adv;
  logic            out_valid_q;

  assign s1_adv        = s1_valid_q & (~s1_last_q | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | s1_adv;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  lesf_pkg::side_t side;
  lesf_pkg::cand_t cand;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_char_q    <= s_axis_tdata;
      s1_last_q    <= s_axis_tlast;
      s1_pos_q.col <= col_new;
      s1_pos_q.row <= row_new;
      // The cell leaving the stage at this edge writes the entry being read; pass its side on.
      fwd_q        <= s1_adv && (s1_pos_q.col == col_new);
      fwd_side_q   <= side;
    end
  end

  // Line buffer: sides of the previous row, one read and one write per cycle.
  lesf_pkg::side_t line_mem [ColLimit];

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[s1_pos_q.col[AddrW-1:0]] <= side;
    end
    if (in_acc) begin
      rdata_q <= line_mem[col_new[AddrW-1:0]];
    end
  end

  // Neighbor sides and the recurrence.
  lesf_pkg::side_t left_q;
  lesf_pkg::side_t diag_q;
  lesf_pkg::side_t up_raw;
  lesf_pkg::nbr_t  nbr;
  lesf_pkg::side_t best_side_q;
  lesf_pkg::row_t  best_row_q;
  lesf_pkg::col_t  best_col_q;

  always_comb begin
    up_raw   = fwd_q ? fwd_side_q : rdata_q;
    nbr.up   = (s1_pos_q.row != '0) ? up_raw : '0;
    nbr.diag = (s1_pos_q.row != '0 && s1_pos_q.col != '0) ? diag_q : '0;
    nbr.left = (s1_pos_q.col != '0) ? left_q : '0;
  end

  lesf_side u_side (
    .cell_char_i (s1_char_q),
    .obstacle_i  (obstacle_q),
    .nbr_i       (nbr),
    .pos_i       (s1_pos_q),
    .best_side_i (best_side_q),
    .side_o      (side),
    .cand_o      (cand)
  );

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_q <= side;
      diag_q <= nbr.up;
    end
  end

  // Best square so far, restarted after every final cell.
  lesf_pkg::side_t best_side_d;
  lesf_pkg::row_t  best_row_d;
  lesf_pkg::col_t  best_col_d;

  always_comb begin
    if (cand.update) begin
      best_side_d = side;
      best_row_d  = cand.row;
      best_col_d  = cand.col;
    end else begin
      best_side_d = best_side_q;
      best_row_d  = best_row_q;
      best_col_d  = best_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_side_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        best_side_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else begin
        best_side_q <= best_side_d;
        best_row_q  <= best_row_d;
        best_col_q  <= best_col_d;
      end
    end
  end

  // Output register.
  lesf_pkg::row_t  out_row_q;
  lesf_pkg::col_t  out_col_q;
  lesf_pkg::side_t out_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      out_row_q  <= best_row_d;
      out_col_q  <= best_col_d;
      out_side_q <= best_side_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_side_q, out_col_q, out_row_q};

endmodule

[rtl/lesf_side.sv]
module lesf_side (
  input  lesf_pkg::char_t cell_char_i,
  input  lesf_pkg::char_t obstacle_i,
  input  lesf_pkg::nbr_t  nbr_i,
  input  lesf_pkg::pos_t  pos_i,
  input  lesf_pkg::side_t best_side_i,
  output lesf_pkg::side_t side_o,
  output lesf_pkg::cand_t cand_o
);

  localparam int unsigned SideW = lesf_pkg::SideW;
  localparam int unsigned RowW  = lesf_pkg::RowW;
  localparam int unsigned ColW  = lesf_pkg::ColW;

  lesf_pkg::side_t min_ud;
  lesf_pkg::side_t min_all;
  logic [SideW:0]  side_inc;
  lesf_pkg::side_t side;
  lesf_pkg::side_t side_m1;

  always_comb begin
    min_ud   = (nbr_i.up < nbr_i.diag) ? nbr_i.up : nbr_i.diag;
    min_all  = (min_ud < nbr_i.left) ? min_ud : nbr_i.left;
    side_inc = {1'b0, min_all} + (SideW+1)'(1);
    if (cell_char_i == obstacle_i) begin
      side = '0;
    end else if (side_inc > (SideW+1)'(lesf_pkg::SideCap)) begin
      side = SideW'(lesf_pkg::SideCap);
    end else begin
      side = side_inc[SideW-1:0];
    end
    side_m1 = side - SideW'(1);
  end

  always_comb begin
    side_o        = side;
    cand_o.update = side > best_side_i;
    // The top-left corner clamps at zero where the square would reach past the map edge.
    if ({1'b0, pos_i.row} >= (RowW+1)'(side_m1)) begin
      cand_o.row = pos_i.row - RowW'(side_m1);
    end else begin
      cand_o.row = '0;
    end
    if ({1'b0, pos_i.col} >= side_m1) begin
      cand_o.col = ColW'({1'b0, pos_i.col} - side_m1);
    end else begin
      cand_o.col = '0;
    end
  end

endmodule
